// ----- design/icto_pkg.sv -----
`default_nettype none

package icto_pkg;

  // Widths of the fixed payload fields.
  localparam int FREQ_W  = 24;
  localparam int PV_W    = 32;
  localparam int SCALE_W = 32;

  // The phase step is (frequency * scale) shifted right by this many bits.
  localparam int STEP_SHIFT = 16;

  // Interpolation weight width, taken from the top of the phase fraction.
  localparam int FRAC_W = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd24932236;

  // Command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // pi/2 in Q2.30, used when the cosine table is built.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Denominators (2k-1)*2k of the Taylor terms of cos, k = 1..10.
  localparam longint unsigned TAYLOR_DEN [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

endpackage

`default_nettype wire

// ----- design/icto_in_if.sv -----
`default_nettype none

interface icto_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [icto_pkg::FREQ_W-1:0]  frequency;
  logic [icto_pkg::PV_W-1:0]    phase_value;

  modport source (output valid, command, frequency, phase_value, input ready);
  modport sink (input valid, command, frequency, phase_value, output ready);
endinterface

`default_nettype wire

// ----- design/icto_out_if.sv -----
`default_nettype none

interface icto_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

`default_nettype wire

// ----- design/icto_rom.sv -----
`default_nettype none

module icto_rom #(
  parameter int TABLE_SIZE  = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [$clog2(TABLE_SIZE)-1:0]     addr0,
  input  wire logic [$clog2(TABLE_SIZE):0]       addr1,
  output      logic signed [SAMPLE_BITS-1:0]     y0,
  output      logic signed [SAMPLE_BITS-1:0]     y1
);

  localparam longint unsigned TS = longint'(TABLE_SIZE);
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;

  // Cosine of v * (pi/2) / TABLE_SIZE for v in [0, TABLE_SIZE], built from a
  // Q30 Taylor series, rounded half up and saturated to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] quarter_cos(input longint unsigned v);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sm;
    longint          r;
    x  = (v * icto_pkg::HALF_PI_Q30) / TS;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    sm = longint'(64'd1 << 30);
    for (int k = 1; k <= 10; k++) begin
      t = ((t * x2) >> 30) / icto_pkg::TAYLOR_DEN[k-1];
      if ((k % 2) == 1) begin
        sm = sm - longint'(t);
      end else begin
        sm = sm + longint'(t);
      end
    end
    if (sm < 0) begin
      sm = 0;
    end
    r = longint'((longint'(unsigned'(sm)) + (longint'(1) <<< (30 - SAMPLE_BITS)))
                 >>> (31 - SAMPLE_BITS));
    if (r > SAMPLE_MAX) begin
      r = SAMPLE_MAX;
    end
    return SAMPLE_BITS'(r);
  endfunction

  // Full-cycle entry from quadrant symmetry; the last entry repeats the first.
  function automatic logic signed [SAMPLE_BITS-1:0] cos_entry(input longint unsigned i);
    longint unsigned u;
    logic signed [SAMPLE_BITS-1:0] c;
    u = 4 * (i % TS);
    if (u <= TS) begin
      c = quarter_cos(u);
    end else if (u < 2 * TS) begin
      c = -quarter_cos(2 * TS - u);
    end else if (u <= 3 * TS) begin
      c = -quarter_cos(u - 2 * TS);
    end else begin
      c = quarter_cos(4 * TS - u);
    end
    return c;
  endfunction

  logic signed [SAMPLE_BITS-1:0] rom [0:TABLE_SIZE];

  for (genvar gi = 0; gi <= TABLE_SIZE; gi++) begin : g_rom
    assign rom[gi] = cos_entry(longint'(gi));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y0 <= rom[{1'b0, addr0}];
      y1 <= rom[addr1];
    end
  end

endmodule

`default_nettype wire

// ----- design/icto_phase.sv -----
`default_nettype none

module icto_phase #(
  parameter int TABLE_SIZE = 512,
  parameter int PHASE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [icto_pkg::SCALE_W-1:0]        cfg_wdata,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic                                command,
  input  wire logic [icto_pkg::FREQ_W-1:0]         frequency,
  input  wire logic [icto_pkg::PV_W-1:0]           phase_value,
  input  wire logic                                rd_ready,
  output      logic                                rd_issue,
  output      logic [$clog2(TABLE_SIZE)-1:0]       addr0,
  output      logic [$clog2(TABLE_SIZE):0]         addr1,
  output      logic [icto_pkg::FRAC_W-1:0]         frac
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int FW     = PHASE_BITS - IDX_W;
  localparam int PROD_W = icto_pkg::FREQ_W + icto_pkg::SCALE_W + 1;

  logic [icto_pkg::SCALE_W-1:0] scale;
  logic                         a_valid;
  logic                         a_cmd;
  logic [PHASE_BITS-1:0]        a_step;
  logic [PHASE_BITS-1:0]        a_pv;
  logic [PHASE_BITS-1:0]        phase;

  logic                         accept;
  logic                         a_go;
  logic signed [PROD_W-1:0]     prod;
  logic signed [63:0]           prod_x;
  logic [PHASE_BITS+31:0]       pv_wide;
  logic [FW+icto_pkg::FRAC_W-1:0] frac_src;

  assign accept = in_valid && in_ready;
  assign a_go   = a_valid && (a_cmd == icto_pkg::CMD_LOAD || rd_ready);
  assign in_ready = !a_valid || a_go;
  assign rd_issue = a_valid && a_cmd == icto_pkg::CMD_SAMPLE && rd_ready;

  // Signed frequency times unsigned scale; the floor shift is a bit-select.
  assign prod   = $signed(frequency) * $signed({1'b0, scale});
  assign prod_x = 64'(prod);

  // Align the Q0.32 phase value with the accumulator's binary point.
  assign pv_wide = {phase_value, {PHASE_BITS{1'b0}}};

  // Table size is a power of two, so index and weight are fields of the phase.
  assign addr0    = phase[PHASE_BITS-1 -: IDX_W];
  assign addr1    = {1'b0, addr0} + (IDX_W + 1)'(1);
  assign frac_src = {phase[FW-1:0], {icto_pkg::FRAC_W{1'b0}}};
  assign frac     = frac_src[FW+icto_pkg::FRAC_W-1 -: icto_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      scale   <= icto_pkg::SCALE_RESET;
      a_valid <= 1'b0;
      phase   <= '0;
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_go) begin
        a_valid <= 1'b0;
      end
      if (a_go) begin
        if (a_cmd == icto_pkg::CMD_LOAD) begin
          phase <= a_pv;
        end else begin
          phase <= phase + a_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd  <= command;
      a_step <= prod_x[icto_pkg::STEP_SHIFT+PHASE_BITS-1 : icto_pkg::STEP_SHIFT];
      a_pv   <= pv_wide[PHASE_BITS+31 : 32];
    end
  end

endmodule

`default_nettype wire

// ----- design/icto_interp.sv -----
`default_nettype none

module icto_interp #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                rd_issue,
  output      logic                                rd_ready,
  input  wire logic [icto_pkg::FRAC_W-1:0]         frac,
  input  wire logic signed [SAMPLE_BITS-1:0]       y0,
  input  wire logic signed [SAMPLE_BITS-1:0]       y1,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic [SAMPLE_BITS-1:0]              sample
);

  localparam int PROD_W = SAMPLE_BITS + icto_pkg::FRAC_W + 2;
  localparam int SUM_W  = SAMPLE_BITS + icto_pkg::FRAC_W + 3;

  logic                          c_valid;
  logic [icto_pkg::FRAC_W-1:0]   c_frac;
  logic                          d_valid;
  logic signed [SAMPLE_BITS-1:0] d_y0;
  logic signed [PROD_W-1:0]      d_prod;

  logic                          c_go;
  logic                          d_go;
  logic                          d_ready;
  logic                          e_ready;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SUM_W-1:0]              acc;

  assign e_ready  = !out_valid || out_ready;
  assign d_ready  = !d_valid || e_ready;
  assign rd_ready = !c_valid || d_ready;
  assign c_go     = c_valid && d_ready;
  assign d_go     = d_valid && e_ready;

  // The table registers hold the two neighbors while this stage is stalled.
  assign diff = (SAMPLE_BITS + 1)'(y1) - (SAMPLE_BITS + 1)'(y0);

  // Rounded floor of (y0 * 2^16 + diff * frac) / 2^16.
  assign acc = (SUM_W'(d_y0) << icto_pkg::FRAC_W) + SUM_W'(d_prod)
             + (SUM_W'(1) << (icto_pkg::FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_issue) begin
        c_valid <= 1'b1;
      end else if (c_go) begin
        c_valid <= 1'b0;
      end
      if (c_go) begin
        d_valid <= 1'b1;
      end else if (d_go) begin
        d_valid <= 1'b0;
      end
      if (d_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      c_frac <= frac;
    end
    if (c_go) begin
      d_y0   <= y0;
      d_prod <= diff * $signed({1'b0, c_frac});
    end
    if (d_go) begin
      sample <= acc[SAMPLE_BITS+icto_pkg::FRAC_W-1 : icto_pkg::FRAC_W];
    end
  end

endmodule

`default_nettype wire

// ----- design/interpolated_cosine_table_oscillator.sv -----
`default_nettype none

// Channel     Dir  Payload                                  Beat taken when
// request     in   command, frequency, phase_value          valid && ready
// result      out  sample                                   valid && ready
// cfg_we      in   cfg_wdata (step_per_hz_scale)            cfg_we high
//
// One request beat per cycle unless result stalls. A sample beat passes through
// the input register, table read, interpolation product and output register to
// result. The phase accumulator adds one step per sample beat; a set-phase beat
// gives no result. Reset is synchronous and clears the phase and the scale to
// their defaults; the cosine table is constant and needs no fill. A stall on
// result backs up stage by stage, filling empty stages before request stalls.

module interpolated_cosine_table_oscillator #(
  parameter int TABLE_SIZE  = 512,
  parameter int PHASE_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  icto_in_if.sink                            request,
  icto_out_if.source                         result,
  input  wire logic                          cfg_we,
  input  wire logic [icto_pkg::SCALE_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic                          rd_issue;
  logic                          rd_ready;
  logic [IDX_W-1:0]              addr0;
  logic [IDX_W:0]                addr1;
  logic [icto_pkg::FRAC_W-1:0]   frac;
  logic signed [SAMPLE_BITS-1:0] y0;
  logic signed [SAMPLE_BITS-1:0] y1;
  logic                          res_valid;
  logic [SAMPLE_BITS-1:0]        res_sample;
  logic                          req_ready;

  icto_phase #(
    .TABLE_SIZE (TABLE_SIZE),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (request.valid),
    .in_ready    (req_ready),
    .command     (request.command),
    .frequency   (request.frequency),
    .phase_value (request.phase_value),
    .rd_ready    (rd_ready),
    .rd_issue    (rd_issue),
    .addr0       (addr0),
    .addr1       (addr1),
    .frac        (frac)
  );

  icto_rom #(
    .TABLE_SIZE  (TABLE_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk   (clk),
    .en    (rd_issue),
    .addr0 (addr0),
    .addr1 (addr1),
    .y0    (y0),
    .y1    (y1)
  );

  icto_interp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .rd_issue  (rd_issue),
    .rd_ready  (rd_ready),
    .frac      (frac),
    .y0        (y0),
    .y1        (y1),
    .out_valid (res_valid),
    .out_ready (result.ready),
    .sample    (res_sample)
  );

  assign request.ready = req_ready;
  assign result.valid  = res_valid;
  assign result.sample = res_sample;

endmodule

`default_nettype wire
